FILE: rtl/c4lh_pkg.sv
// ============================================================================
// c4lh_pkg: shared types, seeds and CRC32C functions
// Constants and XOR-network helpers for the four-lane CRC32C hash.
// ============================================================================
package c4lh_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int LANE_COUNT          = 4;
   localparam int WORD_BYTES          = 8;

   localparam logic [31:0] SEED_ZERO  = 32'h811c_9dc5;
   localparam logic [31:0] SEED_ONE   = 32'hc1ae_e535;
   localparam logic [31:0] SEED_TWO   = 32'h5f35_6495;
   localparam logic [31:0] SEED_THREE = 32'h9e37_79b9;
   localparam logic [31:0] CRC_POLY   = 32'h82f6_3b78;

   // Four lane accumulators, lane 0 in element 0.
   typedef struct packed {
      logic [31:0] lane3;
      logic [31:0] lane2;
      logic [31:0] lane1;
      logic [31:0] lane0;
   } lanes_type;

   // One registered input word, less the length field.
   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic        last_item;
   } item_type;

   localparam lanes_type LANE_SEEDS = '{
      lane3: SEED_THREE, lane2: SEED_TWO, lane1: SEED_ONE, lane0: SEED_ZERO};

   // Reflected CRC32C, one byte, no inversion.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] din);
      logic [31:0] c;
      c = crc ^ {24'h0, din};
      for (int b = 0; b < 8; b++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   // Eight bytes, low byte first.
   function automatic logic [31:0] crc_word64(input logic [31:0] crc, input logic [63:0] din);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < WORD_BYTES; i++) begin
         c = crc_byte(c, din[8*i +: 8]);
      end
      return c;
   endfunction

   // Four bytes, low byte first.
   function automatic logic [31:0] crc_word32(input logic [31:0] crc, input logic [31:0] din);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 4; i++) begin
         c = crc_byte(c, din[8*i +: 8]);
      end
      return c;
   endfunction

   // Pack the first nbytes bytes, first byte most significant; last four kept.
   function automatic logic [31:0] pack_tail(input logic [63:0] din, input logic [2:0] nbytes);
      logic [31:0] p;
      p = '0;
      for (int k = 0; k < WORD_BYTES - 1; k++) begin
         if (3'(k) < nbytes) begin
            p = {p[23:0], din[8*k +: 8]};
         end
      end
      return p;
   endfunction

endpackage

FILE: rtl/c4lh_lane_update.sv
// ============================================================================
// c4lh_lane_update: next-state logic for the four CRC lanes
// Lane steering, CRC XOR networks, word index advance and hash fold.
// ============================================================================
module c4lh_lane_update #(
   parameter int LENGTH_BITS = c4lh_pkg::LENGTH_BITS_DEFAULT
) (
   input  c4lh_pkg::lanes_type      lanes_cur,
   input  logic [LENGTH_BITS-4:0]   word_index_cur,
   input  c4lh_pkg::item_type       item,
   input  logic [LENGTH_BITS-1:0]   total_length,
   output c4lh_pkg::lanes_type      lanes_nxt,
   output logic [LENGTH_BITS-4:0]   word_index_nxt,
   output logic [63:0]              hash_value
);
   import c4lh_pkg::*;

   localparam int IDX_W = LENGTH_BITS - 3;

   logic             full_word;
   logic [IDX_W-1:0] block_words;
   logic             in_blocks;
   logic [1:0]       lane_sel;
   logic [31:0]      lane_src;
   logic [31:0]      lane_crc;
   logic [31:0]      zero_tail;
   logic [31:0]      part_tail;

   // Anything at or above 8 is a full word.
   assign full_word   = item.valid_bytes[3];
   // Words inside whole 64-byte blocks: floor(len/64)*8.
   assign block_words = {total_length[LENGTH_BITS-1:6], 3'b000};
   assign in_blocks   = word_index_cur < block_words;
   assign lane_sel    = in_blocks ? word_index_cur[1:0] : 2'd0;

   always_comb begin
      case (lane_sel)
         2'd0:    lane_src = lanes_cur.lane0;
         2'd1:    lane_src = lanes_cur.lane1;
         2'd2:    lane_src = lanes_cur.lane2;
         default: lane_src = lanes_cur.lane3;
      endcase
   end

   assign lane_crc  = crc_word64(lane_src, item.data_word);
   assign zero_tail = crc_word32(lane_crc, 32'h0);
   assign part_tail = crc_word32(lanes_cur.lane0,
                                 pack_tail(item.data_word, item.valid_bytes[2:0]));

   always_comb begin
      lanes_nxt      = lanes_cur;
      word_index_nxt = word_index_cur;
      if (full_word) begin
         word_index_nxt = word_index_cur + 1'b1;
         case (lane_sel)
            2'd0:    lanes_nxt.lane0 = item.last_item ? zero_tail : lane_crc;
            2'd1:    lanes_nxt.lane1 = lane_crc;
            2'd2:    lanes_nxt.lane2 = lane_crc;
            default: lanes_nxt.lane3 = lane_crc;
         endcase
         // Closing zero tail always lands on lane 0.
         if (item.last_item && lane_sel != 2'd0) begin
            lanes_nxt.lane0 = crc_word32(lanes_cur.lane0, 32'h0);
         end
      end else begin
         lanes_nxt.lane0 = part_tail;
      end
   end

   assign hash_value = {lanes_nxt.lane0, lanes_nxt.lane1} ^ {lanes_nxt.lane2, lanes_nxt.lane3};

endmodule

FILE: rtl/crc32c_four_lane_hash.sv
// ============================================================================
// crc32c_four_lane_hash: four-lane CRC32C message hash
// Streams 64-bit words into four CRC32C lanes and folds them on the last word.
// ============================================================================
// The input reg loads on the accept edge and the result reg when the last word
// leaves the input reg; the hash is then on rsp. Throughput: one word per cycle
// while req_stall is low; the lane update is a single XOR network pass.
// req_stall rises only when a last word sits in the input reg while an earlier
// hash is still held and stalled on the rsp side.
// Reset: lanes return to their seeds, word index to zero, both stages empty.
// ============================================================================
module crc32c_four_lane_hash #(
   parameter int LENGTH_BITS = c4lh_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // input words
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [63:0]            req_data_word,
   input  logic [3:0]             req_valid_bytes,
   input  logic [LENGTH_BITS-1:0] req_total_length,
   input  logic                   req_last_item,
   // hash results
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_hash_value
);
   import c4lh_pkg::*;

   localparam int IDX_W = LENGTH_BITS - 3;

   // --- input register stage ---
   logic                   s1_valid_ff, s1_valid_in;
   item_type               s1_item_ff;
   logic [LENGTH_BITS-1:0] s1_length_ff;

   // --- lane state ---
   lanes_type              lanes_ff, lanes_in;
   logic [IDX_W-1:0]       word_index_ff, word_index_in;

   // --- result register ---
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            rsp_hash_ff;

   lanes_type              lanes_upd;
   logic [IDX_W-1:0]       word_index_upd;
   logic [63:0]            hash_upd;

   logic                   rsp_free;
   logic                   s1_advance;
   logic                   s1_fire;
   logic                   s1_emit;

   // Result slot is free if empty or being drained this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   // Only a last word needs the result slot; other words always move on.
   assign s1_advance = !s1_valid_ff || !s1_item_ff.last_item || rsp_free;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign s1_emit    = s1_fire && s1_item_ff.last_item;
   assign req_stall  = !s1_advance;

   assign s1_valid_in = s1_advance ? req_valid : s1_valid_ff;

   c4lh_lane_update #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_lane_update (
      .lanes_cur      (lanes_ff),
      .word_index_cur (word_index_ff),
      .item           (s1_item_ff),
      .total_length   (s1_length_ff),
      .lanes_nxt      (lanes_upd),
      .word_index_nxt (word_index_upd),
      .hash_value     (hash_upd)
   );

   // Last word folds the lanes out and reseeds for the next message.
   always_comb begin
      lanes_in      = lanes_ff;
      word_index_in = word_index_ff;
      if (s1_fire) begin
         if (s1_item_ff.last_item) begin
            lanes_in      = LANE_SEEDS;
            word_index_in = '0;
         end else begin
            lanes_in      = lanes_upd;
            word_index_in = word_index_upd;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         lanes_ff      <= LANE_SEEDS;
         word_index_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         lanes_ff      <= lanes_in;
         word_index_ff <= word_index_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_item_ff.data_word   <= req_data_word;
         s1_item_ff.valid_bytes <= req_valid_bytes;
         s1_item_ff.last_item   <= req_last_item;
         s1_length_ff           <= req_total_length;
      end
      if (s1_emit) begin
         rsp_hash_ff <= hash_upd;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // --- checks ---
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !s1_emit)
      else $error("held hash overwritten");

   a_reseed: assert property (@(posedge clock) disable iff (reset)
      s1_emit |=> (lanes_ff == LANE_SEEDS) && (word_index_ff == '0))
      else $error("lanes not reseeded after last word");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !s1_emit) |=> !rsp_valid_ff)
      else $error("hash raised without a last word");

   a_partial_index: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_item_ff.valid_bytes[3] && !s1_item_ff.last_item)
         |=> (word_index_ff == $past(word_index_ff)))
      else $error("partial word moved the word index");

endmodule
